/* design/cld_pkg.sv */
// cld_pkg: shared types, constants and the header key table for the content-length deframer
// no dependencies
package cld_pkg;

	localparam int LENGTH_BITS = 32;
	localparam int ACC_BITS = LENGTH_BITS + 4;
	localparam int KEY_LEN = 15;
	localparam int POS_BITS = $clog2(KEY_LEN + 1);

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef logic [LENGTH_BITS-1:0] length_t;
	typedef logic [ACC_BITS-1:0] acc_t;
	typedef logic [POS_BITS-1:0] pos_t;

	localparam length_t LEN_MAX = '1;

	typedef enum logic [1:0] {
		PH_LINE,
		PH_SKIP_LINE,
		PH_SKIP_BODY,
		PH_BODY
	} phase_t;

	typedef enum logic [2:0] {
		LS_EMPTY,
		LS_PREFIX,
		LS_OTHER,
		LS_BLANKS,
		LS_DIGITS,
		LS_DONE,
		LS_BAD
	} line_status_t;

	typedef enum logic [1:0] {
		KIND_BODY,
		KIND_EMPTY,
		KIND_EOS,
		KIND_ERROR
	} kind_t;

	typedef struct packed {
		logic valid;
		kind_t kind;
		logic [7:0] data;
		logic last;
	} result_t;

	function automatic logic [7:0] key_char(input pos_t pos);
		logic [7:0] c;
		case (pos)
			4'd0: c = "c";
			4'd1: c = "o";
			4'd2: c = "n";
			4'd3: c = "t";
			4'd4: c = "e";
			4'd5: c = "n";
			4'd6: c = "t";
			4'd7: c = "-";
			4'd8: c = "l";
			4'd9: c = "e";
			4'd10: c = "n";
			4'd11: c = "g";
			4'd12: c = "t";
			4'd13: c = "h";
			4'd14: c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* design/cld_in_reg.sv */
// cld_in_reg: input register stage holding one accepted request
// depends on nothing but the advance signal from the top level
module cld_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_ready,
	input  logic [7:0] data_byte,
	input  logic       stream_end,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       end_s1
);

	assign data_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ready && data_valid) begin
			byte_s1 <= data_byte;
			end_s1 <= stream_end;
		end
	end

endmodule

/* design/cld_core.sv */
// cld_core: framing state and the per-byte header parse and body count
// depends on cld_pkg
module cld_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      byte_in,
	input  logic            end_in,
	output cld_pkg::result_t res
);

	cld_pkg::phase_t phase_q, phase_d;
	cld_pkg::line_status_t ls_q, ls_d;
	cld_pkg::pos_t pos_q, pos_d;
	logic have_q, have_d;
	cld_pkg::length_t len_q, len_d;
	cld_pkg::length_t rem_q, rem_d;

	logic [7:0] lc;
	logic is_digit;
	logic [3:0] digit;
	cld_pkg::acc_t acc;

	always_comb begin
		lc = (byte_in inside {["A":"Z"]}) ? byte_in + cld_pkg::CASE_OFFSET : byte_in;
		is_digit = byte_in inside {["0":"9"]};
		digit = 4'(byte_in - cld_pkg::CHAR_ZERO);
		acc = (cld_pkg::acc_t'(len_q) << 3) + (cld_pkg::acc_t'(len_q) << 1)
			+ cld_pkg::acc_t'(digit);
	end

	always_comb begin
		phase_d = phase_q;
		ls_d = ls_q;
		pos_d = pos_q;
		have_d = have_q;
		len_d = len_q;
		rem_d = rem_q;
		res = '0;
		res.kind = cld_pkg::KIND_BODY;

		if (end_in) begin
			res.valid = 1'b1;
			res.kind = (phase_q == cld_pkg::PH_LINE &&
				(ls_q == cld_pkg::LS_BLANKS || ls_q == cld_pkg::LS_BAD)) ?
				cld_pkg::KIND_ERROR : cld_pkg::KIND_EOS;
			phase_d = cld_pkg::PH_LINE;
			ls_d = cld_pkg::LS_EMPTY;
			pos_d = '0;
			have_d = 1'b0;
			len_d = '0;
			rem_d = '0;
		end else begin
			case (phase_q)
				cld_pkg::PH_BODY: begin
					res.valid = 1'b1;
					res.data = byte_in;
					res.last = (rem_q <= cld_pkg::length_t'(1));
					if (res.last) begin
						phase_d = cld_pkg::PH_LINE;
						ls_d = cld_pkg::LS_EMPTY;
						pos_d = '0;
						have_d = 1'b0;
						len_d = '0;
						rem_d = '0;
					end else begin
						rem_d = rem_q - cld_pkg::length_t'(1);
					end
				end
				cld_pkg::PH_SKIP_LINE: begin
					phase_d = cld_pkg::PH_LINE;
				end
				cld_pkg::PH_SKIP_BODY: begin
					phase_d = cld_pkg::PH_BODY;
				end
				default: begin
					if (byte_in == cld_pkg::CHAR_CR) begin
						phase_d = cld_pkg::PH_SKIP_LINE;
						if (ls_q == cld_pkg::LS_EMPTY) begin
							if (!have_q || len_q == '0) begin
								res.valid = 1'b1;
								res.kind = have_q ? cld_pkg::KIND_EMPTY : cld_pkg::KIND_ERROR;
								pos_d = '0;
								have_d = 1'b0;
								len_d = '0;
								rem_d = '0;
							end else begin
								rem_d = len_q;
								pos_d = '0;
								phase_d = cld_pkg::PH_SKIP_BODY;
							end
						end else if (ls_q == cld_pkg::LS_BLANKS || ls_q == cld_pkg::LS_BAD) begin
							res.valid = 1'b1;
							res.kind = cld_pkg::KIND_ERROR;
							ls_d = cld_pkg::LS_EMPTY;
							pos_d = '0;
							have_d = 1'b0;
							len_d = '0;
							rem_d = '0;
						end else begin
							ls_d = cld_pkg::LS_EMPTY;
							pos_d = '0;
						end
					end else begin
						case (ls_q)
							cld_pkg::LS_EMPTY, cld_pkg::LS_PREFIX: begin
								if (ls_q == cld_pkg::LS_EMPTY) begin
									pos_d = '0;
								end
								if (lc == cld_pkg::key_char(ls_q == cld_pkg::LS_EMPTY ?
									'0 : pos_q)) begin
									pos_d = (ls_q == cld_pkg::LS_EMPTY) ?
										cld_pkg::pos_t'(1) : pos_q + cld_pkg::pos_t'(1);
									ls_d = (pos_d == cld_pkg::pos_t'(cld_pkg::KEY_LEN)) ?
										cld_pkg::LS_BLANKS : cld_pkg::LS_PREFIX;
								end else begin
									ls_d = cld_pkg::LS_OTHER;
								end
							end
							cld_pkg::LS_BLANKS: begin
								if (byte_in == cld_pkg::CHAR_SPACE || byte_in == cld_pkg::CHAR_TAB) begin
									ls_d = cld_pkg::LS_BLANKS;
								end else if (is_digit) begin
									ls_d = cld_pkg::LS_DIGITS;
									have_d = 1'b1;
									len_d = cld_pkg::length_t'(digit);
								end else begin
									ls_d = cld_pkg::LS_BAD;
								end
							end
							cld_pkg::LS_DIGITS: begin
								if (is_digit) begin
									len_d = (acc[cld_pkg::ACC_BITS-1:cld_pkg::LENGTH_BITS] != '0) ?
										cld_pkg::LEN_MAX : acc[cld_pkg::LENGTH_BITS-1:0];
								end else begin
									ls_d = cld_pkg::LS_DONE;
								end
							end
							default: begin
								ls_d = ls_q;
							end
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cld_pkg::PH_LINE;
			ls_q <= cld_pkg::LS_EMPTY;
			pos_q <= '0;
			have_q <= 1'b0;
			len_q <= '0;
			rem_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			ls_q <= ls_d;
			pos_q <= pos_d;
			have_q <= have_d;
			len_q <= len_d;
			rem_q <= rem_d;
		end
	end

endmodule

/* design/cld_out_reg.sv */
// cld_out_reg: result register that holds one result until the receiver takes it
// depends on cld_pkg
module cld_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  cld_pkg::result_t res,
	output logic             result_valid,
	input  logic             result_ready,
	output logic [1:0]       kind,
	output logic [7:0]       body_byte,
	output logic             body_last
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind <= res.kind;
			body_byte <= res.data;
			body_last <= res.last;
		end
	end

endmodule

/* design/content_length_deframer.sv */
// content_length_deframer: top level joining input register, framing core and result register
// depends on cld_pkg, cld_in_reg, cld_core, cld_out_reg
//
// usage:
//   data channel (data_valid/data_ready) carries one stream byte or an end-of-stream
//   mark per request; result channel (result_valid/result_ready) carries kind,
//   body_byte and body_last
//   header lines end at CR, the byte after each CR is dropped, a content-length
//   line sets the body size, a blank line starts the body
//   body bytes come out one per input byte, the last one flagged
//   errors, empty bodies and end of stream give a single result each
//   a result is registered in the result register when its request leaves the input register
//   throughput: one request per cycle unless a stalled result holds it up, set by the
//   state update in the core between the input and result registers
//   requests that give no result pass through even while the result is stalled
//   a stalled receiver holds the result; a request that gives a result waits,
//   and data_ready drops once the input register is also full
//   reset clears the valid flags of both registers and returns the parser to the
//   start of a header line with no length seen
module content_length_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_ready,
	input  logic [7:0] data_byte,
	input  logic       stream_end,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [1:0] kind,
	output logic [7:0] body_byte,
	output logic       body_last
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic end_s1;
	logic advance;
	cld_pkg::result_t res;

	assign advance = valid_s1 && (!res.valid || !result_valid || result_ready);

	cld_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.data_byte  (data_byte),
		.stream_end (stream_end),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1),
		.end_s1     (end_s1)
	);

	cld_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.byte_in (byte_s1),
		.end_in  (end_s1),
		.res     (res)
	);

	cld_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && res.valid),
		.res          (res),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.body_byte    (body_byte),
		.body_last    (body_last)
	);

endmodule

/* design/cld_checker.sv */
// cld_checker: port-level assertions for content_length_deframer
// depends on cld_pkg; bound to the top level below
module cld_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       data_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [1:0] kind,
	input logic [7:0] body_byte,
	input logic       body_last
);

	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !result_valid)
		else $error("result valid during reset");

	a_last_is_body: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && body_last |-> kind == cld_pkg::KIND_BODY)
		else $error("last flag on a non-body result");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind != cld_pkg::KIND_BODY |-> body_byte == 8'h00 && !body_last)
		else $error("non-body result carries data");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> data_ready)
		else $error("input stalled with empty result slot");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(kind)
		&& $stable(body_byte) && $stable(body_last))
		else $error("stalled result changed");

endmodule

bind content_length_deframer cld_checker u_cld_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.data_ready   (data_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.kind         (kind),
	.body_byte    (body_byte),
	.body_last    (body_last)
);

/* test/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking bench for content_length_deframer, random framed byte streams checked
// against an in-bench parser model; depends on cld_pkg and the deframer rtl

module tb;

	typedef enum int {
		PACE_RX_SLOW,
		PACE_TX_SLOW,
		PACE_FULL
	} pace_t;

	typedef struct {
		logic [7:0] data;
		logic       eos;
		pace_t      pace;
		bit         drain_first;
		bit         rx_hold;
	} stream_req_t;

	typedef struct {
		cld_pkg::kind_t kind;
		logic [7:0]     data;
		logic           last;
	} frame_out_t;

	localparam int ITEM_TOTAL = 850;
	localparam int RX_HOLD_CYCLES = 60;
	localparam int PRINT_CAP = 100;
	localparam logic [8*cld_pkg::KEY_LEN-1:0] LENGTH_KEY = "content-length:";
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       data_valid = 1'b0;
	logic       data_ready;
	logic [7:0] data_byte = 8'h00;
	logic       stream_end = 1'b0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] body_byte;
	logic       body_last;

	stream_req_t stream_queue[$];
	frame_out_t  expected_frames[$];
	int          mismatches = 0;
	bit          req_taken = 1'b0;
	pace_t       pace = PACE_RX_SLOW;
	int          hold_token = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	// parser state
	cld_pkg::phase_t       ph;
	int                    key_pos;
	cld_pkg::line_status_t line_st;
	bit                    seen_length;
	cld_pkg::length_t      length_acc;
	logic [31:0]           lines_done;
	cld_pkg::length_t      bytes_left;

	content_length_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_ready(data_ready),
		.data_byte(data_byte),
		.stream_end(stream_end),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.kind(kind),
		.body_byte(body_byte),
		.body_last(body_last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [7:0] key_at(input int p);
		return LENGTH_KEY[8*(cld_pkg::KEY_LEN-1-p) +: 8];
	endfunction

	function automatic void clear_message();
		key_pos = 0;
		line_st = cld_pkg::LS_EMPTY;
		seen_length = 1'b0;
		length_acc = '0;
		lines_done = '0;
		bytes_left = '0;
	endfunction

	function automatic bit deframe_byte(input logic [7:0] b, input logic eos,
			output frame_out_t res);
		logic [7:0]       lc;
		cld_pkg::length_t d;
		bit               last;
		res.kind = cld_pkg::KIND_BODY;
		res.data = 8'h00;
		res.last = 1'b0;
		if (eos) begin
			res.kind = (ph == cld_pkg::PH_LINE &&
				(line_st == cld_pkg::LS_BLANKS || line_st == cld_pkg::LS_BAD)) ?
				cld_pkg::KIND_ERROR : cld_pkg::KIND_EOS;
			ph = cld_pkg::PH_LINE;
			clear_message();
			return 1'b1;
		end
		case (ph)
			cld_pkg::PH_BODY: begin
				last = (bytes_left <= 1);
				if (last) begin
					clear_message();
					ph = cld_pkg::PH_LINE;
				end else begin
					bytes_left = bytes_left - 1;
				end
				res.data = b;
				res.last = last;
				return 1'b1;
			end
			cld_pkg::PH_SKIP_LINE: begin
				ph = cld_pkg::PH_LINE;
				return 1'b0;
			end
			cld_pkg::PH_SKIP_BODY: begin
				ph = cld_pkg::PH_BODY;
				return 1'b0;
			end
			default: ;
		endcase
		if (b != cld_pkg::CHAR_CR) begin
			lc = (b >= "A" && b <= "Z") ? b + cld_pkg::CASE_OFFSET : b;
			d = cld_pkg::length_t'(b - cld_pkg::CHAR_ZERO);
			case (line_st)
				cld_pkg::LS_EMPTY, cld_pkg::LS_PREFIX: begin
					if (line_st == cld_pkg::LS_EMPTY)
						key_pos = 0;
					if (key_pos < cld_pkg::KEY_LEN && lc == key_at(key_pos)) begin
						key_pos++;
						line_st = (key_pos == cld_pkg::KEY_LEN) ?
							cld_pkg::LS_BLANKS : cld_pkg::LS_PREFIX;
					end else begin
						line_st = cld_pkg::LS_OTHER;
					end
				end
				cld_pkg::LS_BLANKS: begin
					if (!(b == cld_pkg::CHAR_SPACE || b == cld_pkg::CHAR_TAB)) begin
						if (b >= cld_pkg::CHAR_ZERO && b <= CHAR_NINE) begin
							line_st = cld_pkg::LS_DIGITS;
							seen_length = 1'b1;
							length_acc = d;
						end else begin
							line_st = cld_pkg::LS_BAD;
						end
					end
				end
				cld_pkg::LS_DIGITS: begin
					if (b >= cld_pkg::CHAR_ZERO && b <= CHAR_NINE)
						length_acc = (length_acc > (cld_pkg::LEN_MAX - d) / 10) ?
							cld_pkg::LEN_MAX : length_acc * 10 + d;
					else
						line_st = cld_pkg::LS_DONE;
				end
				default: ;
			endcase
			return 1'b0;
		end
		// end of a header line
		if (lines_done != '1)
			lines_done++;
		ph = cld_pkg::PH_SKIP_LINE;
		if (line_st == cld_pkg::LS_EMPTY) begin
			if (!seen_length) begin
				clear_message();
				res.kind = cld_pkg::KIND_ERROR;
				return 1'b1;
			end
			if (length_acc == 0) begin
				clear_message();
				res.kind = cld_pkg::KIND_EMPTY;
				return 1'b1;
			end
			bytes_left = length_acc;
			key_pos = 0;
			ph = cld_pkg::PH_SKIP_BODY;
			return 1'b0;
		end
		if (line_st == cld_pkg::LS_BLANKS || line_st == cld_pkg::LS_BAD) begin
			clear_message();
			res.kind = cld_pkg::KIND_ERROR;
			return 1'b1;
		end
		line_st = cld_pkg::LS_EMPTY;
		key_pos = 0;
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	task automatic push_byte(input logic [7:0] b, input logic eos);
		stream_req_t r;
		r.data = b;
		r.eos = eos;
		if (stream_queue.size() < ITEM_TOTAL / 3)
			r.pace = PACE_RX_SLOW;
		else if (stream_queue.size() < 2 * ITEM_TOTAL / 3)
			r.pace = PACE_TX_SLOW;
		else
			r.pace = PACE_FULL;
		r.drain_first = stream_queue.size() > 0 && stream_queue[$].pace != r.pace;
		r.rx_hold = 1'b0;
		stream_queue.insert(stream_queue.size(), r);
	endtask

	task automatic push_line_end();
		push_byte(cld_pkg::CHAR_CR, 1'b0);
		push_byte(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : CHAR_LF, 1'b0);
	endtask

	task automatic push_length_line(input string value);
		logic [7:0] c;
		for (int i = 0; i < cld_pkg::KEY_LEN; i++) begin
			c = key_at(i);
			if (c >= "a" && c <= "z" && $urandom_range(1))
				c = c - cld_pkg::CASE_OFFSET;
			push_byte(c, 1'b0);
		end
		repeat ($urandom_range(0, 3))
			push_byte($urandom_range(1) ? cld_pkg::CHAR_SPACE : cld_pkg::CHAR_TAB, 1'b0);
		for (int i = 0; i < value.len(); i++)
			push_byte(value[i], 1'b0);
	endtask

	task automatic push_junk_line();
		int n;
		int r;
		if ($urandom_range(4) == 0) begin
			// truncated key, an ordinary header
			n = $urandom_range(1, cld_pkg::KEY_LEN - 1);
			for (int i = 0; i < n; i++)
				push_byte(key_at(i), 1'b0);
		end else begin
			repeat ($urandom_range(1, 10)) begin
				r = $urandom_range(8'h1F, 8'hFF);
				push_byte((r == 8'h1F) ? cld_pkg::CHAR_TAB : 8'(r), 1'b0);
			end
		end
		push_line_end();
	endtask

	task automatic push_message();
		int    pick;
		int    size;
		string txt;
		pick = $urandom_range(99);
		if (pick < 6) begin
			repeat ($urandom_range(1, 12))
				push_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
			return;
		end
		repeat ($urandom_range(0, 2))
			push_junk_line();
		if (pick < 12) begin
			// length line without a value
			case ($urandom_range(3))
				0: txt = "";
				1: txt = "+5";
				2: txt = "-1";
				default: txt = "x12";
			endcase
			push_length_line(txt);
			if ($urandom_range(3) == 0)
				push_byte(8'($urandom_range(255)), 1'b1);
			else
				push_line_end();
			return;
		end
		if (pick < 16) begin
			push_line_end();
			return;
		end
		if (pick < 24) begin
			// maximal or oversized value, later line wins
			case ($urandom_range(2))
				0: txt = "4294967295";
				1: txt = "4294967296";
				default: begin
					txt = $sformatf("%0d", $urandom_range(1, 9));
					repeat ($urandom_range(10, 18))
						txt = {txt, $sformatf("%0d", $urandom_range(9))};
				end
			endcase
			push_length_line(txt);
			push_line_end();
			repeat ($urandom_range(0, 1))
				push_junk_line();
		end
		size = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
		txt = $sformatf("%0d", size);
		if ($urandom_range(4) == 0)
			txt = {"00", txt};
		if ($urandom_range(4) == 0)
			txt = {txt, "; charset"};
		push_length_line(txt);
		push_line_end();
		repeat ($urandom_range(0, 1))
			push_junk_line();
		push_line_end();
		for (int i = 0; i < size; i++) begin
			if ($urandom_range(49) == 0) begin
				push_byte(8'($urandom_range(255)), 1'b1);
				return;
			end
			push_byte(8'($urandom_range(255)), 1'b0);
		end
		if ($urandom_range(19) == 0)
			push_byte(8'($urandom_range(255)), 1'b1);
	endtask

	always @(negedge clk) begin : drive_requests
		int idle_pct;
		if (arst_n && (!data_valid || req_taken)) begin
			idle_pct = 0;
			if (stream_queue.size() != 0)
				idle_pct = (stream_queue[0].pace == PACE_RX_SLOW) ? 17 :
					(stream_queue[0].pace == PACE_TX_SLOW) ? 88 : 0;
			if (stream_queue.size() != 0 &&
					!(stream_queue[0].drain_first && expected_frames.size() != 0) &&
					$urandom_range(99) >= idle_pct) begin
				data_valid <= 1'b1;
				data_byte <= stream_queue[0].data;
				stream_end <= stream_queue[0].eos;
				pace <= stream_queue[0].pace;
				if (stream_queue[0].rx_hold)
					hold_token <= hold_token + 1;
				stream_queue.delete(0);
			end else begin
				data_valid <= 1'b0;
				data_byte <= 8'($urandom_range(255));
				stream_end <= 1'($urandom_range(1));
			end
		end
	end

	always @(negedge clk) begin : accept_results
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = RX_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= $urandom_range(99) >=
				((pace == PACE_RX_SLOW) ? 88 : (pace == PACE_TX_SLOW) ? 17 : 0);
		end
	end

	always @(posedge clk) begin : check_results
		frame_out_t pred;
		frame_out_t want;
		req_taken = arst_n && data_valid && data_ready;
		if (req_taken) begin
			if (deframe_byte(data_byte, stream_end, pred))
				expected_frames.insert(expected_frames.size(), pred);
		end
		if (arst_n && result_valid && result_ready) begin
			if (expected_frames.size() == 0) begin
				report_mismatch($sformatf("result kind %0d with nothing expected", kind));
			end else begin
				want = expected_frames.pop_front();
				if (kind != want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
				if (body_byte != want.data)
					report_mismatch($sformatf("body_byte %02h, expected %02h",
						body_byte, want.data));
				if (body_last != want.last)
					report_mismatch($sformatf("body_last %0b, expected %0b",
						body_last, want.last));
			end
		end
	end

	initial begin : run_stream
		string txt;
		int    hold_at;
		int    after_hold;
		ph = cld_pkg::PH_LINE;
		clear_message();
		// mixed case key, blanks, one body byte, then end of stream and a bare blank line
		txt = "CoNTENT-length: \t1";
		for (int i = 0; i < txt.len(); i++)
			push_byte(txt[i], 1'b0);
		push_byte(cld_pkg::CHAR_CR, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(cld_pkg::CHAR_CR, 1'b0);
		push_byte(CHAR_LF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(cld_pkg::CHAR_CR, 1'b0);
		push_byte(8'hFF, 1'b0);
		after_hold = -1;
		while (stream_queue.size() < ITEM_TOTAL) begin
			if (after_hold < 0 && stream_queue.size() >= 2 * ITEM_TOTAL / 3) begin
				// long receiver hold while a body streams in
				push_byte(8'($urandom_range(255)), 1'b1);
				hold_at = stream_queue.size();
				push_length_line("40");
				stream_queue[hold_at].rx_hold = 1'b1;
				push_line_end();
				push_line_end();
				repeat (40)
					push_byte(8'($urandom_range(255)), 1'b0);
				after_hold = stream_queue.size();
			end
			push_message();
		end
		stream_queue[after_hold].drain_first = 1'b1;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (stream_queue.size() != 0 || data_valid)
			@(posedge clk);
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
